// ----- hw/rtl/nonzero_sample_statistics_unit_defines.svh -----
// Assertion macros for the statistics unit checker.
`ifndef NONZERO_SAMPLE_STATISTICS_UNIT_DEFINES_SVH
`define NONZERO_SAMPLE_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/nss_pkg.sv -----
// Shared types and constants of the nonzero sample statistics unit.
package nss_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SQ_BITS    = 64;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_SINGLE    = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic square;
        logic update;
        logic clear;
    } acc_ctl_t;

endpackage

// ----- hw/rtl/nss_accum.sv -----
// Running min, max, sum, square sum and count of the nonzero samples.
module nss_accum
    import nss_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_SAMPLES = 65535
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  acc_ctl_t                                ctl,
    input  logic signed [SAMPLE_BITS-1:0]           sample,
    output logic signed [SAMPLE_BITS-1:0]           run_min,
    output logic signed [SAMPLE_BITS-1:0]           run_max,
    output logic signed [SAMPLE_BITS+COUNT_BITS-1:0] run_sum,
    output logic [SQ_BITS-1:0]                      run_sq,
    output logic [COUNT_BITS-1:0]                   run_count,
    output logic                                    run_ovf
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(MAX_SAMPLES);

    logic [SAMPLE_BITS-1:0]          mag;
    logic [PROD_BITS-1:0]            sq_prod;
    logic [PROD_BITS-1:0]            sq_reg;
    logic [SQ_BITS:0]                sq_add;
    logic signed [SAMPLE_BITS-1:0]   min_reg;
    logic signed [SAMPLE_BITS-1:0]   max_reg;
    logic signed [SUM_BITS-1:0]      sum_reg;
    logic [SQ_BITS-1:0]              sqsum_reg;
    logic [COUNT_BITS-1:0]           count_reg;
    logic                            ovf_reg;

    assign mag     = sample[SAMPLE_BITS-1] ? (~$unsigned(sample) + SAMPLE_BITS'(1))
                                           : $unsigned(sample);
    assign sq_prod = PROD_BITS'(mag) * PROD_BITS'(mag);
    assign sq_add  = {1'b0, sqsum_reg} + {1'b0, SQ_BITS'(sq_reg)};

    // square register is pure payload
    always_ff @(posedge clk)
    begin
        if (ctl.square)
        begin
            sq_reg <= sq_prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= SMAX;
            max_reg   <= SMIN;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            min_reg   <= SMAX;
            max_reg   <= SMIN;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (ctl.update && (sample != '0))
        begin
            if (count_reg >= COUNT_LIMIT)
            begin
                // drop the sample, flag saturation
                ovf_reg <= 1'b1;
            end
            else
            begin
                if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
                if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                sum_reg   <= sum_reg + SUM_BITS'(sample);
                sqsum_reg <= sq_add[SQ_BITS] ? {SQ_BITS{1'b1}} : sq_add[SQ_BITS-1:0];
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    assign run_min   = min_reg;
    assign run_max   = max_reg;
    assign run_sum   = sum_reg;
    assign run_sq    = sqsum_reg;
    assign run_count = count_reg;
    assign run_ovf   = ovf_reg;

endmodule

// ----- hw/rtl/nss_arith.sv -----
// Shared bit-serial unit: shift-add multiply, restoring divide, integer square root.
module nss_arith
    import nss_pkg::*;
#(
    parameter int WIDTH = 80
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  arith_cmd_t       cmd,
    input  logic [WIDTH-1:0] opnd_a,
    input  logic [WIDTH-1:0] opnd_b,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_STEPS = CNT_BITS'(WIDTH);
    localparam logic [CNT_BITS-1:0] ROOT_STEPS = CNT_BITS'(WIDTH / 2);

    logic [WIDTH-1:0]    a_reg;
    logic [WIDTH-1:0]    b_reg;
    logic [WIDTH-1:0]    c_reg;
    arith_op_t           op_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [WIDTH-1:0]    rs_div;
    logic [WIDTH-1:0]    rs_root;
    logic [WIDTH-1:0]    trial;
    logic [WIDTH-1:0]    add_x;
    logic [WIDTH-1:0]    add_y;
    logic                add_sub;
    logic [WIDTH:0]      add_full;
    logic                ge;
    logic [WIDTH-1:0]    add_res;

    assign rs_div  = {a_reg[WIDTH-2:0], c_reg[WIDTH-1]};
    assign rs_root = {a_reg[WIDTH-3:0], c_reg[WIDTH-1 -: 2]};
    assign trial   = {b_reg[WIDTH-3:0], 2'b01};

    // the one adder; carry out of a subtract means x >= y
    always_comb
    begin
        unique case (op_reg)
            OP_MUL:
            begin
                add_x   = a_reg;
                add_y   = b_reg;
                add_sub = 1'b0;
            end
            OP_DIV:
            begin
                add_x   = rs_div;
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            OP_SQRT:
            begin
                add_x   = rs_root;
                add_y   = trial;
                add_sub = 1'b1;
            end
            default:
            begin
                add_x   = a_reg;
                add_y   = b_reg;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_full = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + (WIDTH + 1)'(add_sub);
    assign ge       = add_full[WIDTH];
    assign add_res  = add_full[WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                busy_reg <= 1'b1;
                cnt_reg  <= (cmd.op == OP_SQRT) ? ROOT_STEPS : FULL_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= '0;
            unique case (cmd.op)
                OP_MUL:
                begin
                    b_reg <= opnd_a;
                    c_reg <= opnd_b;
                end
                OP_DIV:
                begin
                    b_reg <= opnd_b;
                    c_reg <= opnd_a;
                end
                OP_SQRT:
                begin
                    b_reg <= '0;
                    c_reg <= opnd_a;
                end
                default:
                begin
                    b_reg <= opnd_a;
                    c_reg <= opnd_b;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (c_reg[0])
                    begin
                        a_reg <= add_res;
                    end
                    b_reg <= {b_reg[WIDTH-2:0], 1'b0};
                    c_reg <= {1'b0, c_reg[WIDTH-1:1]};
                end
                OP_DIV:
                begin
                    a_reg <= ge ? add_res : rs_div;
                    c_reg <= {c_reg[WIDTH-2:0], ge};
                end
                OP_SQRT:
                begin
                    a_reg <= ge ? add_res : rs_root;
                    b_reg <= {b_reg[WIDTH-2:0], ge};
                    c_reg <= {c_reg[WIDTH-3:0], 2'b00};
                end
                default:
                begin
                    a_reg <= a_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_MUL:  result = a_reg;
            OP_DIV:  result = c_reg;
            OP_SQRT: result = b_reg;
            default: result = a_reg;
        endcase
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/nonzero_sample_statistics_unit.sv -----
// Top level of the nonzero sample statistics unit.
//
// Takes signed Q12.12 samples one item at a time on the input channel and
// skips zero samples. For the nonzero ones it keeps the running minimum,
// maximum, sum, square sum and count. An item with last set is folded in
// first, then one result item follows: min, max, mean (truncated toward
// zero), sample standard deviation floor(sqrt((n*S2 - S*S)/(n*(n-1)))),
// the count and a status code (ok, no nonzero samples, single sample,
// count saturated). The accumulators then clear for the next set.
// Each item passes through accept, square and accumulate, and the input
// channel takes no new item until the last one has been accumulated. A last
// item adds the result computation on the shared bit-serial unit, which
// retires one bit per cycle over NUM_BITS = max(80, 2*(SAMPLE_BITS+16))
// bits: mean divide, two multiplies, variance divide and square root, in
// that order (only the mean divide for a single sample, none for an empty
// set). in_stall stays high throughout. The result sits in an output
// register, so a stalled result does not hold off the next set unless a
// second result is ready before the first is taken.
module nonzero_sample_statistics_unit
    import nss_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_SAMPLES = 65535
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] min_value,
    output logic signed [SAMPLE_BITS-1:0] max_value,
    output logic signed [SAMPLE_BITS-1:0] mean_value,
    output logic [SAMPLE_BITS-2:0]        std_dev,
    output logic [COUNT_BITS-1:0]         sample_count,
    output logic [1:0]                    status
);

    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int NUM_BITS  = (2 * SUM_BITS > SQ_BITS + COUNT_BITS)
                             ? 2 * SUM_BITS : SQ_BITS + COUNT_BITS;
    localparam int DVS_BITS  = 2 * COUNT_BITS;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQUARE = 10'b00_0000_0010,
        S_ACC    = 10'b00_0000_0100,
        S_LAUNCH = 10'b00_0000_1000,
        S_MEAN   = 10'b00_0001_0000,
        S_NSQ    = 10'b00_0010_0000,
        S_SSQ    = 10'b00_0100_0000,
        S_VAR    = 10'b00_1000_0000,
        S_ROOT   = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;

    logic signed [SAMPLE_BITS-1:0]  samp_reg;
    logic                           last_reg;
    logic signed [SAMPLE_BITS-1:0]  mean_reg;
    logic [SAMPLE_BITS-2:0]         sd_reg;
    logic [NUM_BITS-1:0]            nsq_reg;
    logic [DVS_BITS-1:0]            dvs_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  min_out_reg;
    logic signed [SAMPLE_BITS-1:0]  max_out_reg;
    logic signed [SAMPLE_BITS-1:0]  mean_out_reg;
    logic [SAMPLE_BITS-2:0]         sd_out_reg;
    logic [COUNT_BITS-1:0]          count_out_reg;
    logic [1:0]                     status_out_reg;

    acc_ctl_t                       acc_ctl;
    logic signed [SAMPLE_BITS-1:0]  run_min;
    logic signed [SAMPLE_BITS-1:0]  run_max;
    logic signed [SUM_BITS-1:0]     run_sum;
    logic [SQ_BITS-1:0]             run_sq;
    logic [COUNT_BITS-1:0]          run_count;
    logic                           run_ovf;

    arith_cmd_t                     cmd;
    logic [NUM_BITS-1:0]            opnd_a;
    logic [NUM_BITS-1:0]            opnd_b;
    logic                           ar_done;
    logic [NUM_BITS-1:0]            ar_result;

    logic                           sum_neg;
    logic [SUM_BITS-1:0]            sum_mag;
    logic [SAMPLE_BITS-1:0]         quot_lo;
    logic [NUM_BITS-1:0]            numer;
    logic [COUNT_BITS-1:0]          count_m1;
    logic [DVS_BITS-1:0]            dvs_prod;
    logic                           out_free;
    logic                           load_out;
    logic [1:0]                     status_calc;

    nss_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (acc_ctl),
        .sample    (samp_reg),
        .run_min   (run_min),
        .run_max   (run_max),
        .run_sum   (run_sum),
        .run_sq    (run_sq),
        .run_count (run_count),
        .run_ovf   (run_ovf)
    );

    nss_arith #(
        .WIDTH (NUM_BITS)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .done   (ar_done),
        .result (ar_result)
    );

    assign sum_neg  = run_sum[SUM_BITS-1];
    assign sum_mag  = sum_neg ? (~$unsigned(run_sum) + SUM_BITS'(1)) : $unsigned(run_sum);
    // quotient magnitude never exceeds the largest sample magnitude
    assign quot_lo  = ar_result[SAMPLE_BITS-1:0];
    // a negative numerator counts as zero
    assign numer    = (nsq_reg >= ar_result) ? (nsq_reg - ar_result) : '0;
    assign count_m1 = run_count - COUNT_BITS'(1);
    assign dvs_prod = DVS_BITS'(run_count) * DVS_BITS'(count_m1);

    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        priority if (run_count == '0)
        begin
            status_calc = ST_EMPTY;
        end
        else if (run_ovf)
        begin
            status_calc = ST_SATURATED;
        end
        else if (run_count == COUNT_BITS'(1))
        begin
            status_calc = ST_SINGLE;
        end
        else
        begin
            status_calc = ST_OK;
        end
    end

    // sequencer: next state, unit commands and operand selection
    always_comb
    begin
        state_next     = state_reg;
        cmd.start      = 1'b0;
        cmd.op         = OP_MUL;
        opnd_a         = '0;
        opnd_b         = '0;
        acc_ctl.square = 1'b0;
        acc_ctl.update = 1'b0;
        acc_ctl.clear  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                acc_ctl.square = 1'b1;
                state_next     = S_ACC;
            end
            S_ACC:
            begin
                acc_ctl.update = 1'b1;
                state_next     = last_reg ? S_LAUNCH : S_IDLE;
            end
            S_LAUNCH:
            begin
                if (run_count == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // mean magnitude: |sum| / n
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    opnd_a     = NUM_BITS'(sum_mag);
                    opnd_b     = NUM_BITS'(run_count);
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (ar_done)
                begin
                    if (run_count == COUNT_BITS'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // n * S2
                        cmd.start  = 1'b1;
                        cmd.op     = OP_MUL;
                        opnd_a     = NUM_BITS'(run_sq);
                        opnd_b     = NUM_BITS'(run_count);
                        state_next = S_NSQ;
                    end
                end
            end
            S_NSQ:
            begin
                if (ar_done)
                begin
                    // S * S
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    opnd_a     = NUM_BITS'(sum_mag);
                    opnd_b     = NUM_BITS'(sum_mag);
                    state_next = S_SSQ;
                end
            end
            S_SSQ:
            begin
                if (ar_done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    opnd_a     = numer;
                    opnd_b     = NUM_BITS'(dvs_reg);
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                if (ar_done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    opnd_a     = NUM_BITS'(ar_result[SQ_BITS-1:0]);
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (ar_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    acc_ctl.clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            samp_reg <= sample;
            last_reg <= last;
        end
        if (state_reg == S_MEAN)
        begin
            // count is steady while the mean divide runs
            dvs_reg <= dvs_prod;
            if (ar_done)
            begin
                mean_reg <= sum_neg ? (~quot_lo + SAMPLE_BITS'(1)) : quot_lo;
                sd_reg   <= '0;
            end
        end
        if (state_reg == S_NSQ && ar_done)
        begin
            nsq_reg <= ar_result;
        end
        if (state_reg == S_ROOT && ar_done)
        begin
            // saturate at the largest positive sample
            sd_reg <= (ar_result[NUM_BITS-1:SAMPLE_BITS-1] != '0)
                    ? {(SAMPLE_BITS-1){1'b1}} : ar_result[SAMPLE_BITS-2:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            count_out_reg  <= run_count;
            status_out_reg <= status_calc;
            if (run_count == '0)
            begin
                min_out_reg  <= '0;
                max_out_reg  <= '0;
                mean_out_reg <= '0;
                sd_out_reg   <= '0;
            end
            else
            begin
                min_out_reg  <= run_min;
                max_out_reg  <= run_max;
                mean_out_reg <= mean_reg;
                sd_out_reg   <= sd_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign min_value    = min_out_reg;
    assign max_value    = max_out_reg;
    assign mean_value   = mean_out_reg;
    assign std_dev      = sd_out_reg;
    assign sample_count = count_out_reg;
    assign status       = status_out_reg;

endmodule

// ----- hw/rtl/nss_checker.sv -----
// Port-level assertions for the statistics unit, bound to its top level.
`include "nonzero_sample_statistics_unit_defines.svh"

module nss_checker
    import nss_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          last,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] min_value,
    input logic signed [SAMPLE_BITS-1:0] max_value,
    input logic signed [SAMPLE_BITS-1:0] mean_value,
    input logic [SAMPLE_BITS-2:0]        std_dev,
    input logic [COUNT_BITS-1:0]         sample_count,
    input logic [1:0]                    status
);

    logic in_take;
    logic out_hold;

    assign in_take  = in_valid && !in_stall && (sample == sample) && (last == last);
    assign out_hold = out_valid && out_stall;

    `NSS_ASSERT_NEXT(a_out_valid_holds, out_hold, out_valid, "result item dropped while stalled")
    `NSS_ASSERT_NEXT(a_out_payload_holds, out_hold, $stable(mean_value) && $stable(std_dev), "stalled result changed")
    `NSS_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "unit took an item while still working")
    `NSS_ASSERT_NOW(a_single_no_spread, out_valid && (status == ST_SINGLE), (std_dev == '0) && (sample_count == COUNT_BITS'(1)), "single-sample result with nonzero spread")
    `NSS_ASSERT_NOW(a_min_le_max, out_valid && (status != ST_EMPTY), min_value <= max_value, "minimum above maximum")

endmodule

bind nonzero_sample_statistics_unit nss_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_nss_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the nonzero sample statistics unit.
module testbench;

    import nss_pkg::*;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_SAMPLES   = 65535;
    localparam int RANDOM_ITEMS  = 1730;
    localparam int HOLD_CYCLES   = 2500;
    localparam int DRAIN_CYCLES  = 500;
    localparam int DIRECTED_ROWS = 22;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One result item as the unit reports it.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] min_v;
        logic signed [SAMPLE_BITS-1:0] max_v;
        logic signed [SAMPLE_BITS-1:0] mean_v;
        logic [SAMPLE_BITS-2:0]        sd;
        logic [COUNT_BITS-1:0]         cnt;
        logic [1:0]                    st;
    } stats_t;

    // Directed stimulus: a sample, its last flag and, where the answer is
    // obvious, the result typed in by hand.
    typedef struct packed {
        sample_t s;
        logic    lst;
        logic    typed;
        stats_t  want;
    } directed_row_t;

    localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-2:0] SD_MAX = '1;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    sample_t                       cur_sample = '0;
    logic                          cur_last  = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-2:0]        std_dev;
    logic [COUNT_BITS-1:0]         sample_count;
    logic [1:0]                    status;

    // Predictor state: the running statistics of the current set.
    sample_t     tally_min;
    sample_t     tally_max;
    longint      tally_sum;
    logic [63:0] tally_sq;
    int          tally_n;
    bit          tally_ovf;

    stats_t stats_due [$];

    int  items_taken     = 0;
    int  random_items    = 0;
    int  sets_closed     = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  random_phase    = 1'b0;
    logic hold_off       = 1'b0;
    int  stall_left      = 0;
    int  flow_left       = 0;

    // Rows with typed=0 are checked against the predictor alone.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty set right after reset
        '{24'sd0, 1'b1, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 23'd0, 16'd0, ST_EMPTY}},
        '{24'sd0, 1'b0, 1'b0, '0},
        '{24'sd0, 1'b1, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 23'd0, 16'd0, ST_EMPTY}},
        // single samples at both extremes
        '{SMAX, 1'b1, 1'b1, '{SMAX, SMAX, SMAX, 23'd0, 16'd1, ST_SINGLE}},
        '{SMIN, 1'b1, 1'b1, '{SMIN, SMIN, SMIN, 23'd0, 16'd1, ST_SINGLE}},
        // zeros around one sample, zero on the closing item
        '{24'sd0, 1'b0, 1'b0, '0},
        '{24'sd1, 1'b0, 1'b0, '0},
        '{24'sd0, 1'b1, 1'b1, '{24'sd1, 24'sd1, 24'sd1, 23'd0, 16'd1, ST_SINGLE}},
        // widest spread: deviation clips at its top value, mean rounds to zero
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMAX, 1'b1, 1'b1, '{SMIN, SMAX, 24'sd0, SD_MAX, 16'd2, ST_OK}},
        // equal samples, no spread
        '{24'sd4096, 1'b0, 1'b0, '0},
        '{24'sd4096, 1'b0, 1'b0, '0},
        '{24'sd4096, 1'b1, 1'b1, '{24'sd4096, 24'sd4096, 24'sd4096, 23'd0, 16'd3, ST_OK}},
        // negative mean truncated toward zero
        '{-24'sd1, 1'b0, 1'b0, '0},
        '{-24'sd2, 1'b1, 1'b0, '0},
        // alternating bit patterns, mixed with zeros
        '{24'sh555555, 1'b0, 1'b0, '0},
        '{24'shAAAAAA, 1'b0, 1'b0, '0},
        '{24'sd0, 1'b0, 1'b0, '0},
        '{24'sd12288, 1'b0, 1'b0, '0},
        '{-24'sd2048, 1'b1, 1'b0, '0},
        // sum cancels to zero
        '{24'sd1, 1'b0, 1'b0, '0},
        '{-24'sd1, 1'b1, 1'b0, '0}
    };

    nonzero_sample_statistics_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (cur_sample),
        .last         (cur_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .min_value    (min_value),
        .max_value    (max_value),
        .mean_value   (mean_value),
        .std_dev      (std_dev),
        .sample_count (sample_count),
        .status       (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Return the predictor to the empty-set state.
    function automatic void clear_tally();
        tally_min = SMAX;
        tally_max = SMIN;
        tally_sum = 0;
        tally_sq  = '0;
        tally_n   = 0;
        tally_ovf = 1'b0;
    endfunction

    // Floor of the square root, built up one result bit at a time.
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] trial;
        int          i;
        res = '0;
        for (i = 31; i >= 0; i--)
        begin
            trial = res | (64'd1 << i);
            if (trial * trial <= x)
                res = trial;
        end
        return res;
    endfunction

    // Fold one accepted item into the running statistics; on a closing item
    // produce the result, then clear. Returns 1 when a result is due.
    function automatic bit predict_statistics(input sample_t s, input logic lst,
                                              output stats_t r);
        logic [63:0]  mag;
        logic [63:0]  sq;
        logic [63:0]  smag;
        logic [63:0]  quo;
        logic [63:0]  root;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] num;
        logic [127:0] den;
        longint       mean_l;
        r = '0;
        if (s != 0)
        begin
            // A full counter drops the sample and only marks the overflow.
            if (tally_n >= MAX_SAMPLES)
                tally_ovf = 1'b1;
            else
            begin
                mag = (s < 0) ? 64'(-longint'(s)) : 64'(longint'(s));
                sq  = mag * mag;
                tally_sq = (tally_sq > ~sq) ? '1 : tally_sq + sq;
                if (s > tally_max)
                    tally_max = s;
                if (s < tally_min)
                    tally_min = s;
                tally_sum += longint'(s);
                tally_n++;
            end
        end
        if (!lst)
            return 1'b0;
        if (tally_n == 0)
            r.st = ST_EMPTY;
        else
        begin
            mean_l   = tally_sum / longint'(tally_n);
            r.min_v  = tally_min;
            r.max_v  = tally_max;
            r.mean_v = sample_t'(mean_l);
            r.cnt    = COUNT_BITS'(tally_n);
            if (tally_n >= 2)
            begin
                // Exact variance: (n*S2 - S*S) / (n*(n-1)), negative clamps to zero.
                smag = (tally_sum < 0) ? 64'(-tally_sum) : 64'(tally_sum);
                lhs  = 128'(tally_n) * 128'(tally_sq);
                rhs  = 128'(smag) * 128'(smag);
                num  = (lhs > rhs) ? lhs - rhs : '0;
                den  = 128'(tally_n) * 128'(tally_n - 1);
                quo  = 64'(num / den);
                root = root_floor(quo);
                r.sd = (root > 64'(SMAX)) ? SD_MAX : root[SAMPLE_BITS-2:0];
            end
            r.st = tally_ovf ? ST_SATURATED : (tally_n == 1 ? ST_SINGLE : ST_OK);
        end
        clear_tally();
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 300);
    endfunction

    function automatic int pick_set_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    // Sample mix: zeros, extremes, small Q12.12 values and full-range noise.
    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        if (r < 20)
        begin
            case ($urandom_range(0, 3))
                0:       return SMAX;
                1:       return SMIN;
                2:       return sample_t'(1);
                default: return sample_t'(-1);
            endcase
        end
        if (r < 55)
            return $urandom_range(0, 1) ? sample_t'($urandom_range(1, 65535))
                                        : -sample_t'($urandom_range(1, 65535));
        return sample_t'($urandom);
    endfunction

    // Offer one item, hold it until the unit takes it, then advance the
    // predictor. A typed row replaces the predicted result with its own.
    task automatic offer_sample(input sample_t s, input logic lst, input bit no_gaps,
                                input bit typed, input stats_t want);
        int     gap;
        bit     has_result;
        stats_t got;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cur_sample <= s;
        cur_last   <= lst;
        do @(posedge clk); while (in_stall);
        items_taken++;
        if (lst)
            sets_closed++;
        has_result = predict_statistics(s, lst, got);
        if (has_result)
            stats_due.push_back(typed ? want : got);
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Match a taken result item against the oldest one still due.
    task automatic take_result();
        stats_t want;
        if (stats_due.size() == 0)
        begin
            $error("result item with nothing due: min %0d max %0d count %0d status %0d",
                   min_value, max_value, sample_count, status);
            mismatches++;
            return;
        end
        want = stats_due.pop_front();
        compare_field("min_value", $signed(want.min_v), min_value);
        compare_field("max_value", $signed(want.max_v), max_value);
        compare_field("mean_value", $signed(want.mean_v), mean_value);
        compare_field("std_dev", want.sd, std_dev);
        compare_field("sample_count", want.cnt, sample_count);
        compare_field("status", want.st, status);
        status_seen[want.st]++;
        results_checked++;
    endtask

    // Receiver: check each taken result, then pick the next stall value.
    // Alternate free-flowing stretches with stalls of random length, and
    // hold stall high throughout a pressure window.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            take_result();
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (flow_left > 0)
        begin
            out_stall <= 1'b0;
            flow_left--;
        end
        else
        begin
            out_stall  <= 1'b0;
            flow_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(0, 6);
            stall_left = pick_gap();
        end
    end

    // Pressure window: block the output long enough that a second result
    // finishes behind the first and the unit has to stall its input, while
    // the sender keeps offering items.
    initial
    begin
        wait (random_phase);
        repeat (300) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20000000;
        $error("timeout with %0d result items still due", stats_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int    k;
        int    set_len;
        bit    burst;
        bit    empty_set;
        sample_t s;
        clear_tally();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: extremes, empty and single-sample sets, spread limit.
        foreach (directed_rows[i])
            offer_sample(directed_rows[i].s, directed_rows[i].lst, 1'b0,
                         directed_rows[i].typed, directed_rows[i].want);

        // Random sets: mostly short, a few long; some sent with no gaps, some
        // made of zeros only.
        random_phase = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            set_len   = pick_set_len();
            burst     = ($urandom_range(0, 4) == 0);
            empty_set = ($urandom_range(0, 19) == 0);
            for (k = 0; k < set_len; k++)
            begin
                s = empty_set ? sample_t'(0) : pick_sample();
                offer_sample(s, k == set_len - 1, burst, 1'b0, '0);
                random_items++;
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every due result, then allow one more result time.
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input items in %0d sets, with idle gaps and a long output hold",
                 items_taken, sets_closed);
        $display("Checked %0d results: ok %0d, empty %0d, single %0d, saturated %0d",
                 results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_SINGLE], status_seen[ST_SATURATED]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- nonzero_sample_statistics_unit.f -----
+incdir+hw/rtl
hw/rtl/nss_pkg.sv
hw/rtl/nss_accum.sv
hw/rtl/nss_arith.sv
hw/rtl/nonzero_sample_statistics_unit.sv
hw/rtl/nss_checker.sv
test/testbench.sv
